FILE: src/tkst_pkg.sv
// ============================================================================
// tkst_pkg
// Shared types and constants for the keyed top-K score board.
// ============================================================================
`default_nettype none

package tkst_pkg;

  localparam int NAME_LOW_W   = 64;
  localparam int NAME_HIGH_W  = 16;
  localparam int SCORE_W      = 16;
  localparam int RANK_W       = 4;
  localparam int IN_DATA_W    = 96;   // name_low, name_high, score
  localparam int OUT_DATA_W   = 104;  // rank, name_low, name_high, score, zero pad
  localparam int CAPACITY_DEF = 10;

  // One board entry as it sits in the entry memory.
  typedef struct packed {
    logic [SCORE_W-1:0]     score;
    logic [NAME_HIGH_W-1:0] name_high;
    logic [NAME_LOW_W-1:0]  name_low;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,    // wait for a request
    ST_SCAN,    // walk the board: name match, insert point, lowest entry
    ST_DECIDE,  // pick the update
    ST_SEEK,    // find the new place of a raised entry
    ST_EMIT     // rewrite the board in rank order and stream it out
  } state_t;

  typedef enum logic [1:0] {
    MODE_KEEP,   // board unchanged
    MODE_SHIFT,  // one entry moves up or joins; the ones it passes drop by one
    MODE_REPL    // lowest entry leaves, new one joins, younger ages close the gap
  } mode_t;

endpackage : tkst_pkg

`default_nettype wire

FILE: src/top_k_keyed_score_table_unit.sv
// ============================================================================
// top_k_keyed_score_table_unit
// Keyed top-K score board kept in rank order in a synchronous memory.
// ============================================================================
//
// Usage:
//   Input channel (in_tvalid / in_tready / in_tdata) carries one request: a
//   ten-byte player name and a score. A name on the board has its score
//   raised when the new score is higher; a new name joins while there is
//   room, or replaces the lowest entry when its score is strictly greater.
//   Result channel (out_tvalid / out_tready / out_tdata / out_tlast) streams
//   the whole board after every request, rank 1 first, out_tlast on the last.
//   Work per request with N entries on the board after the update: taking
//   the request, one scan read per entry already on the board, a decision
//   step, then the rewrite and emission of all N entries. A raise of a
//   known name held at rank r first reads the r - 1 entries above it to
//   find its new slot. All of this is set by the single read port of the
//   entry memory, one entry per cycle while out_tready does not stall the
//   rewrite pass. The first result follows the scan, the decision step
//   and, for a raise, the seek.
//   in_tready is high only while the unit is between requests.
//   A stall on out_tready freezes the rewrite pass: the read data and the
//   output register hold until the result is taken.
//   Reset empties the board at once (entry count to zero); the memories are
//   not cleared since slots past the count are never shown.
//
`default_nettype none

module top_k_keyed_score_table_unit #(
  parameter int CAPACITY = tkst_pkg::CAPACITY_DEF  // 1 .. 15
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tkst_pkg::IN_DATA_W-1:0] in_tdata,   // name_low, name_high, score
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [tkst_pkg::OUT_DATA_W-1:0]     out_tdata,  // rank, out_name_low,
                                                          // out_name_high, out_score, pad
  output logic                                out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AGE_W = IDX_W;
  localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_LAST   = CNT_W'(CAPACITY - 1);
  localparam logic [AGE_W-1:0] AGE_NEWEST = AGE_W'(CAPACITY - 1);

  // --------------------------------------------------------------------------
  // Board memories, rank order. The age is the join order (0 = oldest) and
  // breaks score ties.
  // --------------------------------------------------------------------------
  tkst_pkg::entry_t   ent_mem [CAPACITY];
  logic [AGE_W-1:0]   age_mem [CAPACITY];

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  tkst_pkg::entry_t   rd_ent_r;
  logic [AGE_W-1:0]   rd_age_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  tkst_pkg::entry_t   wr_ent;
  logic [AGE_W-1:0]   wr_age;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_ent;
      age_mem[wr_addr] <= wr_age;
    end
    if (rd_en) begin
      rd_ent_r <= ent_mem[rd_addr];
      rd_age_r <= age_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control and working registers
  // --------------------------------------------------------------------------
  tkst_pkg::state_t state_r, state_nxt;
  tkst_pkg::mode_t  mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;        // entries on the board
  logic [CNT_W-1:0] k_r, k_nxt;            // slot held in the read data
  tkst_pkg::entry_t key_r, key_nxt;        // request being handled
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] m_r, m_nxt;            // slot of the matching name
  logic [tkst_pkg::SCORE_W-1:0] old_sc_r, old_sc_nxt;
  logic [AGE_W-1:0] age_m_r, age_m_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;            // slot where the moved entry lands
  logic [CNT_W-1:0] hi_r, hi_nxt;          // last slot touched by the shift
  logic [tkst_pkg::SCORE_W-1:0] last_sc_r, last_sc_nxt;
  logic [AGE_W-1:0] last_age_r, last_age_nxt;
  logic [AGE_W-1:0] new_age_r, new_age_nxt;
  tkst_pkg::entry_t carry_r, carry_nxt;    // entry pushed down by one slot
  logic [AGE_W-1:0] carry_age_r, carry_age_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [tkst_pkg::RANK_W-1:0] out_rank_r, out_rank_nxt;
  tkst_pkg::entry_t out_ent_r, out_ent_nxt;
  logic             out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkst_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      mode_r      <= tkst_pkg::MODE_KEEP;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    key_r       <= key_nxt;
    m_r         <= m_nxt;
    old_sc_r    <= old_sc_nxt;
    age_m_r     <= age_m_nxt;
    p_r         <= p_nxt;
    hi_r        <= hi_nxt;
    last_sc_r   <= last_sc_nxt;
    last_age_r  <= last_age_nxt;
    new_age_r   <= new_age_nxt;
    carry_r     <= carry_nxt;
    carry_age_r <= carry_age_nxt;
    out_rank_r  <= out_rank_nxt;
    out_ent_r   <= out_ent_nxt;
    out_last_r  <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic               in_fire;
  logic               step;
  logic [CNT_W-1:0]   k_inc;
  logic               name_hit;
  logic               cnt_last;
  logic [31:0]        rank_wide;
  tkst_pkg::entry_t   new_ent;
  tkst_pkg::entry_t   em_ent;
  logic [AGE_W-1:0]   em_age_raw;
  logic               em_is_new;
  logic               em_take_carry;

  assign in_tready = (state_r == tkst_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign step      = !out_valid_r || out_tready;
  assign k_inc     = k_r + 1'b1;
  assign name_hit  = (rd_ent_r.name_low == key_r.name_low) &&
                     (rd_ent_r.name_high == key_r.name_high);
  assign cnt_last  = (k_r == cnt_r - 1'b1);
  assign rank_wide = 32'(k_r) + 32'd1;
  assign new_ent   = key_r;

  // Pick what lands in slot k during the rewrite pass.
  always_comb begin
    em_is_new     = 1'b0;
    em_take_carry = 1'b0;
    if (mode_r != tkst_pkg::MODE_KEEP && k_r >= p_r && k_r <= hi_r) begin
      if (k_r == p_r) begin
        em_is_new = 1'b1;
      end else begin
        em_take_carry = 1'b1;
      end
    end
    if (em_is_new) begin
      em_ent     = new_ent;
      em_age_raw = new_age_r;
    end else if (em_take_carry) begin
      em_ent     = carry_r;
      em_age_raw = carry_age_r;
    end else begin
      em_ent     = rd_ent_r;
      em_age_raw = rd_age_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    m_nxt         = m_r;
    old_sc_nxt    = old_sc_r;
    age_m_nxt     = age_m_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    last_sc_nxt   = last_sc_r;
    last_age_nxt  = last_age_r;
    new_age_nxt   = new_age_r;
    carry_nxt     = carry_r;
    carry_age_nxt = carry_age_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rank_nxt  = out_rank_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = k_r[IDX_W-1:0];
    wr_ent        = em_ent;
    wr_age        = em_age_raw;

    // Close the age gap left by the removed entry.
    if (mode_r == tkst_pkg::MODE_REPL && !em_is_new && em_age_raw > last_age_r) begin
      wr_age = em_age_raw - 1'b1;
    end

    case (state_r)
      tkst_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_nxt.name_low  = in_tdata[63:0];
          key_nxt.name_high = in_tdata[79:64];
          key_nxt.score     = in_tdata[95:80];
          found_nxt = 1'b0;
          p_nxt     = '0;
          k_nxt     = '0;
          if (cnt_r != '0) begin
            rd_en     = 1'b1;
            state_nxt = tkst_pkg::ST_SCAN;
          end else begin
            state_nxt = tkst_pkg::ST_DECIDE;
          end
        end
      end

      tkst_pkg::ST_SCAN: begin
        if (name_hit && !found_r) begin
          found_nxt  = 1'b1;
          m_nxt      = k_r;
          old_sc_nxt = rd_ent_r.score;
          age_m_nxt  = rd_age_r;
        end
        // every entry scoring at least the new score stays ahead of a newcomer
        if (rd_ent_r.score >= key_r.score) begin
          p_nxt = p_r + 1'b1;
        end
        if (cnt_last) begin
          last_sc_nxt  = rd_ent_r.score;
          last_age_nxt = rd_age_r;
          state_nxt    = tkst_pkg::ST_DECIDE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k_inc[IDX_W-1:0];
          k_nxt   = k_inc;
        end
      end

      tkst_pkg::ST_DECIDE: begin
        k_nxt     = '0;
        rd_en     = 1'b1;
        state_nxt = tkst_pkg::ST_EMIT;
        mode_nxt  = tkst_pkg::MODE_KEEP;
        if (found_r) begin
          if (key_r.score > old_sc_r) begin
            mode_nxt    = tkst_pkg::MODE_SHIFT;
            hi_nxt      = m_r;
            new_age_nxt = age_m_r;
            p_nxt       = '0;
            if (m_r != '0) begin
              state_nxt = tkst_pkg::ST_SEEK;
            end
          end
        end else if (cnt_r != CAP_CNT) begin
          mode_nxt    = tkst_pkg::MODE_SHIFT;
          hi_nxt      = cnt_r;
          new_age_nxt = cnt_r[AGE_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else if (key_r.score > last_sc_r) begin
          mode_nxt    = tkst_pkg::MODE_REPL;
          hi_nxt      = CAP_LAST;
          new_age_nxt = AGE_NEWEST;
        end
      end

      tkst_pkg::ST_SEEK: begin
        // entries above the raised one that still outrank it
        if (rd_ent_r.score > key_r.score ||
            (rd_ent_r.score == key_r.score && rd_age_r < age_m_r)) begin
          p_nxt = p_r + 1'b1;
        end
        rd_en = 1'b1;
        if (k_inc == m_r) begin
          k_nxt     = '0;
          state_nxt = tkst_pkg::ST_EMIT;
        end else begin
          rd_addr = k_inc[IDX_W-1:0];
          k_nxt   = k_inc;
        end
      end

      tkst_pkg::ST_EMIT: begin
        if (step) begin
          wr_en         = (mode_r != tkst_pkg::MODE_KEEP);
          out_valid_nxt = 1'b1;
          out_rank_nxt  = rank_wide[tkst_pkg::RANK_W-1:0];
          out_ent_nxt   = em_ent;
          out_last_nxt  = cnt_last;
          if (em_is_new || em_take_carry) begin
            carry_nxt     = rd_ent_r;
            carry_age_nxt = rd_age_r;
          end
          if (cnt_last) begin
            state_nxt = tkst_pkg::ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k_inc[IDX_W-1:0];
            k_nxt   = k_inc;
          end
        end
      end

      default: begin
        state_nxt = tkst_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_ent_r.score, out_ent_r.name_high,
                       out_ent_r.name_low, out_rank_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tkst_pkg::ST_EMIT |-> cnt_r != '0 && k_r < cnt_r)
    else $error("rewrite pass outside the board");

  a_write_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == tkst_pkg::ST_EMIT && step)
    else $error("memory write outside the rewrite pass");

endmodule : top_k_keyed_score_table_unit

`default_nettype wire
